// ===== rtl/npd_pkg.sv =====
// Shared types and constants for the nearest point distance shader.
// Used by the stream interfaces, the distance cell chain, the square root
// unit and the top level. Depends on nothing.
package npd_pkg;

    // Fixed field widths
    localparam int DIM_W      = 13;   // image width / height registers
    localparam int CNT_W      = 7;    // point count register
    localparam int IDX_W      = 6;    // table slot index of a load request
    localparam int PIX_W      = 12;   // echoed pixel coordinates
    localparam int CHAN_W     = 8;    // one color channel
    localparam int MODE_W     = 4;    // color mode register
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Parameter defaults
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_DIST   = 3'd5;

    // Configuration reset values
    localparam logic [DIM_W-1:0]  IMAGE_DIM_RST   = 13'd256;
    localparam logic [CNT_W-1:0]  POINT_COUNT_RST = 7'd1;

    // Request operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // Channel selection, low three bits of the color mode
    typedef enum logic [2:0] {
        COL_ALL,
        COL_RED,
        COL_GREEN,
        COL_BLUE,
        COL_YELLOW,
        COL_CYAN,
        COL_PINK,
        COL_BLACK
    } color_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ROOT,
        ST_HOLD
    } npd_state_t;

    // Wrap settings broadcast to every cell
    typedef struct packed {
        logic             en;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } wrap_cfg_t;

    // Control part of the query token that walks the cell chain
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] left;
    } tok_ctl_t;

endpackage

// ===== rtl/npd_req_if.sv =====
// Request channel of the nearest point distance shader: load or query.
// Depends on npd_pkg for the slot index width.
interface npd_req_if #(
    parameter int COORD_W = npd_pkg::COORD_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [npd_pkg::IDX_W-1:0]   point_index;
    logic [COORD_W-1:0]          coord_x;
    logic [COORD_W-1:0]          coord_y;

    modport source (
        output valid, operation, point_index, coord_x, coord_y,
        input  ready
    );

    modport sink (
        input  valid, operation, point_index, coord_x, coord_y,
        output ready
    );
endinterface

// ===== rtl/npd_rsp_if.sv =====
// Result channel of the nearest point distance shader: one BGRA pixel.
// Depends on npd_pkg for the field widths.
interface npd_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [npd_pkg::PIX_W-1:0]    pixel_x;
    logic [npd_pkg::PIX_W-1:0]    pixel_y;
    logic [npd_pkg::CHAN_W-1:0]   blue;
    logic [npd_pkg::CHAN_W-1:0]   green;
    logic [npd_pkg::CHAN_W-1:0]   red;
    logic [npd_pkg::CHAN_W-1:0]   alpha;
    logic [npd_pkg::CHAN_W-1:0]   distance_floor;

    modport source (
        output valid, pixel_x, pixel_y, blue, green, red, alpha, distance_floor,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, blue, green, red, alpha, distance_floor,
        output ready
    );
endinterface

// ===== rtl/npd_cell.sv =====
// One cell of the distance chain: holds one feature point, measures the
// squared distance to the passing query and keeps the running minimum.
// Depends on npd_pkg for the wrap settings and token control types.
module npd_cell #(
    parameter int COORD_W = npd_pkg::COORD_BITS_DEF,
    parameter int SQ_W    = 2 * npd_pkg::COORD_BITS_DEF + 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  npd_pkg::wrap_cfg_t     wrap_cfg,
    input  logic                   load_en,
    input  logic [COORD_W-1:0]     load_x,
    input  logic [COORD_W-1:0]     load_y,
    input  npd_pkg::tok_ctl_t      ctl_in,
    input  logic [COORD_W-1:0]     x_in,
    input  logic [COORD_W-1:0]     y_in,
    input  logic [SQ_W-1:0]        best_in,
    output npd_pkg::tok_ctl_t      ctl_out,
    output logic [COORD_W-1:0]     x_out,
    output logic [COORD_W-1:0]     y_out,
    output logic [SQ_W-1:0]        best_out
);
    import npd_pkg::*;

    localparam int EXT_W = (DIM_W > COORD_W) ? DIM_W : COORD_W;
    localparam int PRD_W = 2 * COORD_W;

    // Absolute axis difference, folded to the short way round under wrap
    function automatic logic [COORD_W-1:0] axis_dist(
        input logic [COORD_W-1:0] a,
        input logic [COORD_W-1:0] b,
        input logic [DIM_W-1:0]   size,
        input logic               en
    );
        logic [COORD_W-1:0] d;
        logic [EXT_W-1:0]   d_ext;
        logic [EXT_W-1:0]   s_ext;
        logic [EXT_W-1:0]   alt;
        d     = (a >= b) ? (a - b) : (b - a);
        d_ext = EXT_W'(d);
        s_ext = EXT_W'(size);
        alt   = s_ext - d_ext;
        if (en && (s_ext > d_ext) && (alt < d_ext))
        begin
            d = COORD_W'(alt);
        end
        return d;
    endfunction

    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;
    tok_ctl_t           ctl_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic               act1_reg;
    logic               act2_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [PRD_W-1:0]   sqx_reg;
    logic [PRD_W-1:0]   sqy_reg;
    logic [SQ_W-1:0]    best_reg;

    tok_ctl_t           ctl_next;
    logic               act1_next;
    logic [PRD_W-1:0]   dx_wide;
    logic [PRD_W-1:0]   dy_wide;
    logic [SQ_W-1:0]    sum;

    // Decide participation and count down the remaining points
    always_comb
    begin
        act1_next      = ctl_in.valid && (ctl_in.left != '0);
        ctl_next.valid = ctl_in.valid;
        ctl_next.left  = ctl_in.left - CNT_W'(act1_next);
    end

    assign dx_wide = PRD_W'(dx_reg);
    assign dy_wide = PRD_W'(dy_reg);
    assign sum     = SQ_W'(sqx_reg) + SQ_W'(sqy_reg);

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            act1_reg <= 1'b0;
            act2_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl_next;
            act1_reg <= act1_next;
            act2_reg <= act1_reg;
        end
    end

    // Store the feature point on a load request
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            px_reg <= load_x;
            py_reg <= load_y;
        end
    end

    // Pass coordinates on, measure, square, keep the minimum
    always_ff @(posedge clk)
    begin
        x_reg    <= x_in;
        y_reg    <= y_in;
        dx_reg   <= axis_dist(x_in, px_reg, wrap_cfg.width, wrap_cfg.en);
        dy_reg   <= axis_dist(y_in, py_reg, wrap_cfg.height, wrap_cfg.en);
        sqx_reg  <= dx_wide * dx_wide;
        sqy_reg  <= dy_wide * dy_wide;
        best_reg <= (act2_reg && (sum < best_in)) ? sum : best_in;
    end

    assign ctl_out  = ctl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign best_out = best_reg;

endmodule

// ===== rtl/npd_isqrt.sv =====
// Bit-serial integer square root: one result bit per cycle.
// Gives the floor root and whether a remainder is left. Depends on npd_pkg.
module npd_isqrt #(
    parameter int SQ_W = 2 * npd_pkg::COORD_BITS_DEF + 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SQ_W-1:0]       value,
    output logic                  done,
    output logic [SQ_W/2-1:0]     root,
    output logic                  rem_nz
);
    import npd_pkg::*;

    localparam int ROOT_W = SQ_W / 2;
    localparam int REM_W  = ROOT_W + 1;
    localparam int STP_W  = $clog2(ROOT_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [STP_W-1:0]    cnt_reg;
    logic [SQ_W-1:0]     rad_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;

    logic [REM_W+1:0]    rem_sh;
    logic [REM_W+1:0]    trial;
    logic [REM_W+1:0]    diff;
    logic                take;

    // Bring down the next bit pair and try the new root bit
    assign rem_sh = {rem_reg, rad_reg[SQ_W-1 -: 2]};
    assign trial  = (REM_W + 2)'({root_reg, 2'b01});
    assign diff   = rem_sh - trial;
    assign take   = (rem_sh >= trial);

    // Step counter and done flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= STP_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - STP_W'(1);
            busy_reg <= (cnt_reg != STP_W'(1));
            done_reg <= (cnt_reg == STP_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Radicand, remainder and partial root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    assign done   = done_reg;
    assign root   = root_reg;
    assign rem_nz = (rem_reg != '0);

endmodule

// ===== rtl/nearest_point_distance_shader_top.sv =====
// Top level of the nearest point distance shader: config registers, request
// control, the chain of distance cells, the square root unit and shading.
// Depends on npd_pkg, npd_req_if, npd_rsp_if, npd_cell and npd_isqrt.
//
//  Channel   Direction  Handshake         Carries
//  req       in         valid/ready       operation, point_index, coord_x, coord_y
//  rsp       out        valid/ready       pixel_x, pixel_y, blue, green, red,
//                                         alpha, distance_floor
//  cfg       in         cfg_we            cfg_index, cfg_data
//
//  A load request writes one table slot and gives no result.
//  A query request passes the launch register, the chain of distance cells
//  and the square root unit, which gives one root bit per cycle, and is then
//  shaded into the output register.
//  One request is in work at a time; req.ready is low until its result sits
//  in the output register, which holds it while rsp.ready is low.
//  Reset sets control and configuration to their reset values; the point table is not cleared.
module nearest_point_distance_shader_top #(
    parameter int MAX_POINTS = npd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = npd_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [npd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [npd_pkg::CFG_DATA_W-1:0]  cfg_data,
    npd_req_if.sink                         req,
    npd_rsp_if.source                       rsp
);
    import npd_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS + 2;
    localparam int ROOT_W = SQ_W / 2;
    localparam int RX_W   = (ROOT_W + 1 > CHAN_W + 1) ? ROOT_W + 1 : CHAN_W + 1;

    // Configuration registers
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               wrap_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic               alpha_dist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= IMAGE_DIM_RST;
            height_reg     <= IMAGE_DIM_RST;
            count_reg      <= POINT_COUNT_RST;
            wrap_reg       <= 1'b0;
            mode_reg       <= '0;
            alpha_dist_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg      <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg     <= cfg_data[DIM_W-1:0];
                CFG_POINT_COUNT:  count_reg      <= cfg_data[CNT_W-1:0];
                CFG_WRAP_ENABLE:  wrap_reg       <= cfg_data[0];
                CFG_COLOR_MODE:   mode_reg       <= cfg_data[MODE_W-1:0];
                CFG_ALPHA_DIST:   alpha_dist_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Control state
    npd_state_t         state_reg;
    npd_state_t         state_next;
    tok_ctl_t           launch_reg;
    tok_ctl_t           launch_next;
    logic [1:0]         fin_reg;
    logic               out_vld_reg;
    logic               out_vld_next;

    logic               req_acc;
    logic               out_load;
    logic               root_start;
    logic [CNT_W-1:0]   n_eff;

    wrap_cfg_t          wrap_cfg;
    logic               root_done;
    logic [ROOT_W-1:0]  root;
    logic               rem_nz;

    // Chain taps: the chain input and one past each cell
    tok_ctl_t           tok_ctl [MAX_POINTS+1];
    logic [COORD_BITS-1:0] tok_x [MAX_POINTS+1];
    logic [COORD_BITS-1:0] tok_y [MAX_POINTS+1];
    logic [SQ_W-1:0]    best   [MAX_POINTS+1];

    logic [COORD_BITS-1:0] launch_x_reg;
    logic [COORD_BITS-1:0] launch_y_reg;
    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;

    assign req_acc = req.valid && req.ready;

    // Points searched: zero counts as one, large counts stop at the table size
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (int'(count_reg) > MAX_POINTS)
        begin
            n_eff = CNT_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = count_reg;
        end
    end

    // Next state and request control
    always_comb
    begin
        state_next        = state_reg;
        launch_next.valid = 1'b0;
        launch_next.left  = n_eff;
        req.ready         = 1'b0;
        root_start        = 1'b0;
        out_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid && (req.operation == OP_QUERY))
                begin
                    launch_next.valid = 1'b1;
                    state_next        = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (fin_reg[1])
                begin
                    root_start = 1'b1;
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_vld_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid: set on load, drop once taken
    always_comb
    begin
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            launch_reg  <= '0;
            fin_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            fin_reg     <= {fin_reg[0], tok_ctl[MAX_POINTS].valid};
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold query coordinates for the chain and capture the echo at its end
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            launch_x_reg <= req.coord_x;
            launch_y_reg <= req.coord_y;
        end
        if (tok_ctl[MAX_POINTS].valid)
        begin
            qx_reg <= tok_x[MAX_POINTS];
            qy_reg <= tok_y[MAX_POINTS];
        end
    end

    assign wrap_cfg.en     = wrap_reg;
    assign wrap_cfg.width  = width_reg;
    assign wrap_cfg.height = height_reg;

    assign tok_ctl[0] = launch_reg;
    assign tok_x[0]   = launch_x_reg;
    assign tok_y[0]   = launch_y_reg;
    assign best[0]    = '1;

    // Cell chain, one feature point per cell
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic load_en;

        assign load_en = req_acc && (req.operation == OP_LOAD)
                         && (int'(req.point_index) == i);

        npd_cell #(
            .COORD_W (COORD_BITS),
            .SQ_W    (SQ_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wrap_cfg (wrap_cfg),
            .load_en  (load_en),
            .load_x   (req.coord_x),
            .load_y   (req.coord_y),
            .ctl_in   (tok_ctl[i]),
            .x_in     (tok_x[i]),
            .y_in     (tok_y[i]),
            .best_in  (best[i]),
            .ctl_out  (tok_ctl[i+1]),
            .x_out    (tok_x[i+1]),
            .y_out    (tok_y[i+1]),
            .best_out (best[i+1])
        );
    end

    npd_isqrt #(
        .SQ_W (SQ_W)
    ) u_isqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (root_start),
        .value  (best[MAX_POINTS]),
        .done   (root_done),
        .root   (root),
        .rem_nz (rem_nz)
    );

    // Shade from the floor and ceiling of the distance
    logic [RX_W-1:0]    root_x;
    logic [RX_W-1:0]    ceil_x;
    logic [CHAN_W-1:0]  floor_d;
    logic [CHAN_W-1:0]  ceil_d;
    logic [CHAN_W-1:0]  shade;
    logic [CHAN_W-1:0]  blue_c;
    logic [CHAN_W-1:0]  green_c;
    logic [CHAN_W-1:0]  red_c;
    color_sel_t         sel;

    assign root_x  = RX_W'(root);
    assign ceil_x  = root_x + RX_W'(rem_nz);
    assign floor_d = (root_x >= RX_W'(CHAN_MAX)) ? CHAN_MAX : root_x[CHAN_W-1:0];
    assign ceil_d  = (ceil_x >= RX_W'(CHAN_MAX)) ? CHAN_MAX : ceil_x[CHAN_W-1:0];
    assign shade   = mode_reg[MODE_W-1] ? floor_d : (CHAN_MAX - ceil_d);
    assign sel     = color_sel_t'(mode_reg[2:0]);

    // Route the shade to the channels the mode enables
    always_comb
    begin
        blue_c  = '0;
        green_c = '0;
        red_c   = '0;
        unique case (sel)
            COL_ALL:
            begin
                blue_c  = shade;
                green_c = shade;
                red_c   = shade;
            end
            COL_RED:    red_c   = shade;
            COL_GREEN:  green_c = shade;
            COL_BLUE:   blue_c  = shade;
            COL_YELLOW:
            begin
                green_c = shade;
                red_c   = shade;
            end
            COL_CYAN:
            begin
                blue_c  = shade;
                green_c = shade;
            end
            COL_PINK:
            begin
                blue_c  = shade;
                red_c   = shade;
            end
            COL_BLACK:  ;
            default:    ;
        endcase
    end

    // Output register
    logic [PIX_W-1:0]   pix_x_reg;
    logic [PIX_W-1:0]   pix_y_reg;
    logic [CHAN_W-1:0]  blue_reg;
    logic [CHAN_W-1:0]  green_reg;
    logic [CHAN_W-1:0]  red_reg;
    logic [CHAN_W-1:0]  alpha_reg;
    logic [CHAN_W-1:0]  floor_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pix_x_reg <= PIX_W'(qx_reg);
            pix_y_reg <= PIX_W'(qy_reg);
            blue_reg  <= blue_c;
            green_reg <= green_c;
            red_reg   <= red_c;
            alpha_reg <= alpha_dist_reg ? shade : CHAN_MAX;
            floor_reg <= floor_d;
        end
    end

    assign rsp.valid          = out_vld_reg;
    assign rsp.pixel_x        = pix_x_reg;
    assign rsp.pixel_y        = pix_y_reg;
    assign rsp.blue           = blue_reg;
    assign rsp.green          = green_reg;
    assign rsp.red            = red_reg;
    assign rsp.alpha          = alpha_reg;
    assign rsp.distance_floor = floor_reg;

endmodule
